>>> sv/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg: shared constants for the causal split search
// Register indexes, reset values and field widths used by css_front, css_back and the top.
// ----------------------------------------------------------------------------
`default_nettype none
package css_pkg;

  localparam int unsigned DefaultMaxSamples = 1024;

  localparam int unsigned OutcomeW = 24;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned ImproveW = 48;
  localparam int unsigned SideW    = 11;
  localparam int unsigned GroupW   = 10;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [CfgIdxW-1:0] CfgMinSide  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgMinGroup = 8'd1;

  localparam logic [SideW-1:0]  MinSideReset  = 11'd1;
  localparam logic [GroupW-1:0] MinGroupReset = 10'd2;

endpackage
`default_nettype wire

>>> sv/css_fifo.sv
// ----------------------------------------------------------------------------
// css_fifo: two-entry job queue
// Decouples sample loading from the split sweep.
// ----------------------------------------------------------------------------
`default_nettype none
module css_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_n_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [Width-1:0]      data_o
);
  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_n_o = (cnt_q != 2'd2);
  assign valid_o  = (cnt_q != 2'd0);
  assign data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && full_n_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && full_n_o) wr_q <= ~wr_q;
      if (pop_i && valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'((push_i && full_n_o) ? 1 : 0) - 2'((pop_i && valid_o) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

>>> sv/css_front.sv
// ----------------------------------------------------------------------------
// css_front: sample loader
// Stores samples, forms node totals and queues one job per node.
// ----------------------------------------------------------------------------
`default_nettype none
module css_front #(
  parameter int unsigned MaxSamples = 1024,
  localparam int unsigned AW = $clog2(MaxSamples),
  localparam int unsigned CW = AW + 1,
  localparam int unsigned SW = css_pkg::OutcomeW + AW,
  localparam int unsigned JW = 2 * CW + 2 * SW + css_pkg::SideW + css_pkg::GroupW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [css_pkg::OutcomeW-1:0]  outcome_i,
  input  wire logic                          treated_i,
  input  wire logic [css_pkg::KeyW-1:0]      key_i,
  input  wire logic                          last_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [css_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [css_pkg::SideW-1:0]     cfg_data_i,
  output logic                               mem_we_o,
  output logic [AW-1:0]                      mem_addr_o,
  output logic [css_pkg::OutcomeW-1:0]       mem_y_o,
  output logic                               mem_t_o,
  output logic [css_pkg::KeyW-1:0]           mem_key_o,
  output logic                               job_push_o,
  input  wire logic                          job_full_n_i,
  output logic [JW-1:0]                      job_o,
  input  wire logic                          release_i
);
  import css_pkg::*;

  logic [CW-1:0]        n_q, n_d, w_q, w_d;
  logic signed [SW-1:0] s_q, s_d, t_q, t_d, y_ext;
  logic [SideW-1:0]     ms_q, ms_eff;
  logic [GroupW-1:0]    mg_q, mg_eff;
  logic                 busy_q, acc, store;

  assign ready_o = !busy_q && job_full_n_i;
  assign acc     = valid_i && ready_o;
  assign store   = (n_q < CW'(MaxSamples));
  assign y_ext   = SW'($signed(outcome_i));

  assign mem_we_o   = acc && store;
  assign mem_addr_o = n_q[AW-1:0];
  assign mem_y_o    = outcome_i;
  assign mem_t_o    = treated_i;
  assign mem_key_o  = key_i;

  always_comb begin
    n_d = n_q;
    w_d = w_q;
    s_d = s_q;
    t_d = t_q;
    if (store) begin
      n_d = n_q + CW'(1);
      s_d = s_q + y_ext;
      if (treated_i) begin
        w_d = w_q + CW'(1);
        t_d = t_q + y_ext;
      end
    end
  end

  assign ms_eff     = (ms_q == '0) ? SideW'(1) : ms_q;
  assign mg_eff     = (mg_q == '0) ? GroupW'(1) : mg_q;
  assign job_push_o = acc && last_i;
  assign job_o      = {ms_eff, mg_eff, t_d, s_d, w_d, n_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      w_q    <= '0;
      s_q    <= '0;
      t_q    <= '0;
      ms_q   <= MinSideReset;
      mg_q   <= MinGroupReset;
      busy_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgMinSide:  ms_q <= cfg_data_i;
          CfgMinGroup: mg_q <= cfg_data_i[GroupW-1:0];
          default: ;
        endcase
      end
      if (release_i) busy_q <= 1'b0;
      if (acc) begin
        if (last_i) begin
          n_q    <= '0;
          w_q    <= '0;
          s_q    <= '0;
          t_q    <= '0;
          busy_q <= 1'b1;
        end else begin
          n_q <= n_d;
          w_q <= w_d;
          s_q <= s_d;
          t_q <= t_d;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/css_div.sv
// ----------------------------------------------------------------------------
// css_div: restoring divider
// Unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module css_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);
  localparam int unsigned CtW = $clog2(NW + 1);

  logic [DW:0]    rem_q, rem_sh, rem_sub;
  logic [NW-1:0]  quo_q;
  logic [DW-1:0]  den_q;
  logic [CtW-1:0] cnt_q;
  logic           run_q, done_q, qbit;

  assign rem_sh  = {rem_q[DW-1:0], quo_q[NW-1]};
  assign qbit    = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign done_o  = done_q;
  assign quot_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && !start_i && (cnt_q == CtW'(NW - 1));
      if (start_i) begin
        rem_q <= '0;
        quo_q <= num_i;
        den_q <= den_i;
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= qbit ? rem_sub : rem_sh;
        quo_q <= {quo_q[NW-2:0], qbit};
        cnt_q <= cnt_q + CtW'(1);
        if (cnt_q == CtW'(NW - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/css_back.sv
// ----------------------------------------------------------------------------
// css_back: split sweep engine
// Holds the sample store, scores the node and every eligible boundary.
// ----------------------------------------------------------------------------
`default_nettype none
module css_back #(
  parameter int unsigned MaxSamples = 1024,
  localparam int unsigned AW = $clog2(MaxSamples),
  localparam int unsigned CW = AW + 1,
  localparam int unsigned SW = css_pkg::OutcomeW + AW,
  localparam int unsigned JW = 2 * CW + 2 * SW + css_pkg::SideW + css_pkg::GroupW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          mem_we_i,
  input  wire logic [AW-1:0]                 mem_addr_i,
  input  wire logic [css_pkg::OutcomeW-1:0]  mem_y_i,
  input  wire logic                          mem_t_i,
  input  wire logic [css_pkg::KeyW-1:0]      mem_key_i,
  input  wire logic                          job_valid_i,
  output logic                               job_pop_o,
  input  wire logic [JW-1:0]                 job_i,
  output logic                               release_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               found_o,
  output logic [css_pkg::ImproveW-1:0]       improvement_o,
  output logic [css_pkg::KeyW-1:0]           low_key_o,
  output logic [css_pkg::KeyW-1:0]           high_key_o,
  output logic                               lsmall_o
);
  import css_pkg::*;

  localparam int unsigned PW  = CW + 1 + SW;
  localparam int unsigned NW  = PW + 1;
  localparam int unsigned DW  = 2 * CW;
  localparam int unsigned QW  = 25;
  localparam int unsigned DSW = QW + 1;
  localparam int unsigned SQW = 2 * QW;
  localparam int unsigned PRW = (SQW + CW > 61) ? SQW + CW : 61;
  localparam int unsigned SCW = 61;
  localparam int unsigned GW  = 63;
  localparam int unsigned KW  = (CW > SideW) ? CW : SideW;
  localparam logic [PRW-1:0] CapP = PRW'(1) << 60;
  localparam logic [GW-1:0]  ImpMaxP = GW'({ImproveW{1'b1}});

  typedef enum logic [3:0] {
    ST_IDLE, ST_EMUL, ST_ESUB, ST_EDIV, ST_SQ, ST_SN, ST_SCAP,
    ST_RD0, ST_LD0, ST_RD, ST_EVAL, ST_CHK, ST_ADV, ST_OUT
  } state_e;
  typedef enum logic [1:0] {PH_NODE, PH_LEFT, PH_RIGHT} phase_e;

  logic [OutcomeW-1:0] mem_y [MaxSamples];
  logic                mem_t [MaxSamples];
  logic [KeyW-1:0]     mem_k [MaxSamples];
  logic [OutcomeW-1:0] rd_y_q;
  logic                rd_t_q;
  logic [KeyW-1:0]     rd_k_q;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_y[mem_addr_i] <= mem_y_i;
      mem_t[mem_addr_i] <= mem_t_i;
      mem_k[mem_addr_i] <= mem_key_i;
    end
    if (rd_en) begin
      rd_y_q <= mem_y[rd_addr];
      rd_t_q <= mem_t[rd_addr];
      rd_k_q <= mem_k[rd_addr];
    end
  end

  state_e               state_q;
  phase_e               phase_q;
  logic [CW-1:0]        n_q, w_q, ln_q, lw_q, op_n_q, op_w_q;
  logic signed [SW-1:0] s_q, t_q, ls_q, lt_q, op_s_q, op_t_q;
  logic [SideW-1:0]     ms_q;
  logic [GroupW-1:0]    mg_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic [DW-1:0]        den_q;
  logic                 ok_q, neg_q;
  logic signed [DSW-1:0] d_q, dl_q;
  logic [SQW-1:0]       sq_q;
  logic [PRW-1:0]       prod_q;
  logic [SCW-1:0]       node_q, lsc_q, score;
  logic signed [GW-1:0] best_q, gain;
  logic                 found_q, lsmall_q, out_valid_q, release_q;
  logic [KeyW-1:0]      low_q, high_q, cur_k_q;
  logic [OutcomeW-1:0]  cur_y_q;
  logic                 cur_t_q;
  logic [CW-1:0]        n_j, w_j;
  logic signed [SW-1:0] s_j, t_j;
  logic [SideW-1:0]     ms_j;
  logic [GroupW-1:0]    mg_j;
  logic signed [NW-1:0] num_s;
  logic [NW-1:0]        num_mag, quot;
  logic                 div_start, div_done;
  logic [QW-1:0]        mag;
  logic [CW-1:0]        rn, lc, rw, rc;
  logic                 brk, skip;

  assign {ms_j, mg_j, t_j, s_j, w_j, n_j} = job_i;

  // a new sweep waits until the previous result transaction is taken
  assign job_pop_o   = (state_q == ST_IDLE) && !out_valid_q;
  assign release_o   = release_q;
  assign rd_en       = (state_q == ST_RD0) || (state_q == ST_RD);
  assign rd_addr     = (state_q == ST_RD) ? ln_q[AW-1:0] : '0;

  assign num_s     = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
  assign num_mag   = num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
  assign div_start = (state_q == ST_ESUB) && ok_q;
  assign mag       = d_q[DSW-1] ? QW'(-d_q) : QW'(d_q);
  assign score     = (prod_q > CapP) ? CapP[SCW-1:0] : prod_q[SCW-1:0];
  assign gain      = $signed(GW'(lsc_q)) + $signed(GW'(score)) - $signed(GW'(node_q));

  assign rn = n_q - ln_q;
  assign lc = ln_q - lw_q;
  assign rw = w_q - lw_q;
  assign rc = rn - rw;
  assign brk  = (KW'(rn) < KW'(ms_q));
  assign skip = (KW'(ln_q) < KW'(ms_q)) || (cur_k_q == rd_k_q) ||
                (KW'(lw_q) < KW'(mg_q)) || (KW'(lc) < KW'(mg_q)) ||
                (KW'(rw) < KW'(mg_q)) || (KW'(rc) < KW'(mg_q));

  css_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_mag),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign lsmall_o      = lsmall_q;
  assign low_key_o     = low_q;
  assign high_key_o    = high_q;
  assign improvement_o = (best_q > $signed(ImpMaxP)) ? {ImproveW{1'b1}} : best_q[ImproveW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_NODE;
      n_q <= '0; w_q <= '0; s_q <= '0; t_q <= '0;
      ms_q <= '0; mg_q <= '0;
      ln_q <= '0; lw_q <= '0; ls_q <= '0; lt_q <= '0;
      op_n_q <= '0; op_w_q <= '0; op_s_q <= '0; op_t_q <= '0;
      p1_q <= '0; p2_q <= '0; den_q <= '0; ok_q <= 1'b0; neg_q <= 1'b0;
      d_q <= '0; dl_q <= '0; sq_q <= '0; prod_q <= '0;
      node_q <= '0; lsc_q <= '0; best_q <= '0;
      found_q <= 1'b0; lsmall_q <= 1'b0; low_q <= '0; high_q <= '0;
      cur_k_q <= '0; cur_y_q <= '0; cur_t_q <= 1'b0;
      out_valid_q <= 1'b0;
      release_q <= 1'b0;
    end else begin
      release_q <= (state_q == ST_OUT);
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i && !out_valid_q) begin
            n_q <= n_j; w_q <= w_j; s_q <= s_j; t_q <= t_j;
            ms_q <= ms_j; mg_q <= mg_j;
            op_n_q <= n_j; op_w_q <= w_j; op_s_q <= s_j; op_t_q <= t_j;
            phase_q <= PH_NODE;
            state_q <= ST_EMUL;
          end
        end
        ST_EMUL: begin
          p1_q  <= $signed({1'b0, op_n_q}) * op_t_q;
          p2_q  <= $signed({1'b0, op_w_q}) * op_s_q;
          den_q <= DW'(op_w_q) * DW'(op_n_q - op_w_q);
          ok_q  <= (op_w_q != '0) && (op_w_q < op_n_q);
          state_q <= ST_ESUB;
        end
        ST_ESUB: begin
          neg_q <= num_s[NW-1];
          if (ok_q) begin
            state_q <= ST_EDIV;
          end else begin
            d_q <= '0;
            state_q <= ST_SQ;
          end
        end
        ST_EDIV: begin
          if (div_done) begin
            d_q <= neg_q ? -$signed({1'b0, quot[QW-1:0]}) : $signed({1'b0, quot[QW-1:0]});
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq_q <= mag * mag;
          state_q <= ST_SN;
        end
        ST_SN: begin
          prod_q <= PRW'(sq_q) * PRW'(op_n_q);
          state_q <= ST_SCAP;
        end
        ST_SCAP: begin
          case (phase_q)
            PH_NODE: begin
              node_q <= score;
              ln_q <= CW'(1); lw_q <= '0; ls_q <= '0; lt_q <= '0;
              best_q <= '0; found_q <= 1'b0; lsmall_q <= 1'b0;
              low_q <= '0; high_q <= '0;
              state_q <= (n_q < CW'(2)) ? ST_OUT : ST_RD0;
            end
            PH_LEFT: begin
              lsc_q <= score;
              dl_q  <= d_q;
              op_n_q <= rn; op_w_q <= rw;
              op_s_q <= s_q - ls_q; op_t_q <= t_q - lt_q;
              phase_q <= PH_RIGHT;
              state_q <= ST_EMUL;
            end
            default: begin
              if (gain > best_q) begin
                best_q   <= gain;
                found_q  <= 1'b1;
                low_q    <= cur_k_q;
                high_q   <= rd_k_q;
                lsmall_q <= (dl_q < d_q);
              end
              state_q <= ST_ADV;
            end
          endcase
        end
        ST_RD0: state_q <= ST_LD0;
        ST_LD0: begin
          cur_y_q <= rd_y_q; cur_t_q <= rd_t_q; cur_k_q <= rd_k_q;
          state_q <= ST_RD;
        end
        ST_RD: state_q <= ST_EVAL;
        ST_EVAL: begin
          ls_q <= ls_q + SW'($signed(cur_y_q));
          if (cur_t_q) begin
            lt_q <= lt_q + SW'($signed(cur_y_q));
            lw_q <= lw_q + CW'(1);
          end
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (brk) begin
            state_q <= ST_OUT;
          end else if (skip) begin
            state_q <= ST_ADV;
          end else begin
            op_n_q <= ln_q; op_w_q <= lw_q; op_s_q <= ls_q; op_t_q <= lt_q;
            phase_q <= PH_LEFT;
            state_q <= ST_EMUL;
          end
        end
        ST_ADV: begin
          cur_y_q <= rd_y_q; cur_t_q <= rd_t_q; cur_k_q <= rd_k_q;
          ln_q <= ln_q + CW'(1);
          state_q <= ((ln_q + CW'(1)) < n_q) ? ST_RD : ST_OUT;
        end
        ST_OUT: begin
          out_valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/causal_split_search.sv
// ----------------------------------------------------------------------------
// causal_split_search: treatment-effect split search over one predictor
// Loads a node of sorted samples, then sweeps boundaries for the best gain.
// ----------------------------------------------------------------------------
// Loading: one sample per cycle. The sample marked last starts the sweep.
// Sweep: one node score, then each boundary in turn; an eligible boundary scores its
// left and right sides with the one-bit-per-cycle divider over an NW-bit numerator
// (47 bits at 1024 samples), others are skipped. Input stalls from last until the
// result is registered; a sweep starts only after the previous result is taken.
// Reset clears counters and sums and restores config defaults; no clear pass.
`default_nettype none
module causal_split_search #(
  parameter int unsigned MAX_SAMPLES = css_pkg::DefaultMaxSamples
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // outcome[23:0], treated[24], sort_key[56:25], zero fill
  input  wire logic [63:0]                  s_axis_tdata,
  input  wire logic                         s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // found[0], improvement[48:1], split_low_key[80:49], split_high_key[112:81],
  // left_smaller_effect[113], zero fill
  output logic [119:0]                      m_axis_tdata,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [css_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [css_pkg::SideW-1:0]    cfg_data_i
);
  import css_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = OutcomeW + AW;
  localparam int unsigned JW = 2 * CW + 2 * SW + SideW + GroupW;

  logic                mem_we, mem_t, push, full_n, jvalid, pop, rel;
  logic [AW-1:0]       mem_addr;
  logic [OutcomeW-1:0] mem_y;
  logic [KeyW-1:0]     mem_key, low_key, high_key;
  logic [JW-1:0]       job_in, job_out;
  logic                found, lsmall;
  logic [ImproveW-1:0] improvement;

  assign cfg_ready_o = 1'b1;

  css_front #(.MaxSamples(MAX_SAMPLES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .outcome_i    (s_axis_tdata[23:0]),
    .treated_i    (s_axis_tdata[24]),
    .key_i        (s_axis_tdata[56:25]),
    .last_i       (s_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mem_y_o      (mem_y),
    .mem_t_o      (mem_t),
    .mem_key_o    (mem_key),
    .job_push_o   (push),
    .job_full_n_i (full_n),
    .job_o        (job_in),
    .release_i    (rel)
  );

  css_fifo #(.Width(JW)) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (job_in),
    .full_n_o (full_n),
    .pop_i    (pop),
    .valid_o  (jvalid),
    .data_o   (job_out)
  );

  css_back #(.MaxSamples(MAX_SAMPLES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mem_we_i      (mem_we),
    .mem_addr_i    (mem_addr),
    .mem_y_i       (mem_y),
    .mem_t_i       (mem_t),
    .mem_key_i     (mem_key),
    .job_valid_i   (jvalid),
    .job_pop_o     (pop),
    .job_i         (job_out),
    .release_o     (rel),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .found_o       (found),
    .improvement_o (improvement),
    .low_key_o     (low_key),
    .high_key_o    (high_key),
    .lsmall_o      (lsmall)
  );

  assign m_axis_tdata = {6'd0, lsmall, high_key, low_key, improvement, found};
endmodule
`default_nettype wire
